@@ rtl/refcounted_lru_entry_cache_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the reference-counted LRU entry cache
// Shared property forms used by the modules of the cache core.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_LRU_ENTRY_CACHE_CORE_ASSERT_SVH
`define REFCOUNTED_LRU_ENTRY_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RLEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlec: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RLEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlec: next-cycle check failed");

`endif

@@ rtl/rlec_pkg.sv @@
// ----------------------------------------------------------------------------
// rlec_pkg
// Types, codes and defaults shared by the cache core modules.
// ----------------------------------------------------------------------------
package rlec_pkg;

    localparam int DEF_SLOTS       = 64;
    localparam int DEF_OBJECT_BITS = 24;
    localparam int DEF_REF_BITS    = 16;

    localparam int OBJ_FIELD_W   = 24;
    localparam int SLOT_FIELD_W  = 6;
    localparam int STATUS_W      = 3;
    localparam int COUNT_FIELD_W = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_NO_IDLE     = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_HELD        = 3'd4,
        ST_NOW_IDLE    = 3'd5,
        ST_BAD_RELEASE = 3'd6
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    lookup;
        logic    capture;
        logic    init_wr;
        logic    refs_inc;
        logic    refs_dec;
        logic    fill;
        logic    unlink;
        logic    push1;
        logic    push2;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_put;
        logic hit;
        logic in_range;
        logic refs_zero;
        logic refs_one;
        logic refs_max;
        logic ring_empty;
        logic init_last;
    } t_sts;

endpackage

@@ rtl/rlec_ram.sv @@
// ----------------------------------------------------------------------------
// rlec_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/rlec_cam.sv @@
// ----------------------------------------------------------------------------
// rlec_cam
// Tag store with one compare per entry and a valid bit per entry.
// ----------------------------------------------------------------------------
`include "refcounted_lru_entry_cache_core_assert.svh"

module rlec_cam #(
    parameter int SLOTS       = 64,
    parameter int OBJECT_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [OBJECT_BITS-1:0]   i_key,
    output logic                     o_hit,
    output logic [$clog2(SLOTS)-1:0] o_hit_idx,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_idx,
    input  logic [OBJECT_BITS-1:0]   i_wr_tag
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [OBJECT_BITS-1:0] r_tag [SLOTS];
    logic [SLOTS-1:0]       r_valid;
    logic [SLOTS-1:0]       match;
    logic [IDX_W-1:0]       hit_idx;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            if (i_wr_en && i_wr_idx == IDX_W'(k)) begin
                r_tag[k] <= i_wr_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                if (i_wr_en && i_wr_idx == IDX_W'(k)) begin
                    r_valid[k] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            match[k] = r_valid[k] && (r_tag[k] == i_key);
        end
    end

    // A tag is only written after a miss on it, so at most one entry matches
    // and an OR of the matching indexes is the index itself.
    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (match[k]) begin
                hit_idx = hit_idx | IDX_W'(k);
            end
        end
    end

    assign o_hit     = |match;
    assign o_hit_idx = hit_idx;

    `RLEC_ASSERT_IMPLY(a_single_match, i_clk, i_rst_n, 1'b1, $onehot0(match))

endmodule

@@ rtl/rlec_datapath.sv @@
// ----------------------------------------------------------------------------
// rlec_datapath
// Tag match, reference counts, idle ring pointers and result registers.
// ----------------------------------------------------------------------------
`include "refcounted_lru_entry_cache_core_assert.svh"

module rlec_datapath
    import rlec_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int OBJECT_BITS = DEF_OBJECT_BITS,
    parameter int REF_BITS    = DEF_REF_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_action,
    input  logic [OBJ_FIELD_W-1:0]   i_object_number,
    input  logic [SLOT_FIELD_W-1:0]  i_slot,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_FIELD_W-1:0]  o_slot_index,
    output logic [COUNT_FIELD_W-1:0] o_ref_count,
    output logic                     o_needs_fill
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam logic [PTR_W-1:0]    HEAD    = PTR_W'(SLOTS);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    // Captured request.
    logic                     r_action;
    logic [OBJECT_BITS-1:0]   r_obj;
    logic [SLOT_FIELD_W-1:0]  r_slot;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_hit;
    logic                     r_in_range;
    logic [IDX_W-1:0]         r_victim;
    logic [PTR_W-1:0]         r_q;
    logic [PTR_W-1:0]         r_init_cnt;

    // Staged and presented result words.
    t_status                  r_res_status;
    logic [SLOT_FIELD_W-1:0]  r_res_slot;
    logic [COUNT_FIELD_W-1:0] r_res_count;
    logic                     r_res_fill;
    t_status                  r_out_status;
    logic [SLOT_FIELD_W-1:0]  r_out_slot;
    logic [COUNT_FIELD_W-1:0] r_out_count;
    logic                     r_out_fill;

    logic [OBJECT_BITS-1:0]   key;
    logic                     cam_hit;
    logic [IDX_W-1:0]         cam_idx;
    logic [IDX_W-1:0]         slot_idx;
    logic                     slot_ok;

    logic [REF_BITS-1:0]      refs_rd;
    logic [REF_BITS-1:0]      refs_inc;
    logic [REF_BITS-1:0]      refs_dec;
    logic                     refs_we;
    logic [IDX_W-1:0]         refs_wa;
    logic [REF_BITS-1:0]      refs_wd;
    logic [IDX_W-1:0]         refs_ra;

    logic [PTR_W-1:0]         next_rd;
    logic                     next_we;
    logic [PTR_W-1:0]         next_wa;
    logic [PTR_W-1:0]         next_wd;
    logic [PTR_W-1:0]         next_ra;

    logic [PTR_W-1:0]         prev_rd;
    logic                     prev_we;
    logic [PTR_W-1:0]         prev_wa;
    logic [PTR_W-1:0]         prev_wd;
    logic [PTR_W-1:0]         prev_ra;

    logic [PTR_W-1:0]         idx_ptr;
    t_status                  n_res_status;
    logic [SLOT_FIELD_W-1:0]  n_res_slot;
    logic [COUNT_FIELD_W-1:0] n_res_count;
    logic                     n_res_fill;

    assign key      = OBJECT_BITS'(i_object_number);
    assign slot_idx = IDX_W'(i_slot);
    assign slot_ok  = 32'(i_slot) < 32'(SLOTS);
    assign idx_ptr  = PTR_W'(r_idx);
    assign refs_inc = REF_BITS'(refs_rd + 1'b1);
    assign refs_dec = REF_BITS'(refs_rd - 1'b1);

    rlec_cam #(
        .SLOTS       (SLOTS),
        .OBJECT_BITS (OBJECT_BITS)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (key),
        .o_hit     (cam_hit),
        .o_hit_idx (cam_idx),
        .i_wr_en   (i_cmd.fill),
        .i_wr_idx  (IDX_W'(prev_rd)),
        .i_wr_tag  (r_obj)
    );

    // Read addresses. While idle the reads follow the incoming word so that
    // the data is ready in the evaluate cycle; afterwards they follow the
    // victim pointer for the miss path.
    always_comb begin
        if (i_cmd.lookup) begin
            refs_ra = i_action ? slot_idx : cam_idx;
            prev_ra = (!i_action && cam_hit) ? PTR_W'(cam_idx) : HEAD;
            next_ra = i_action ? HEAD : PTR_W'(cam_idx);
        end else begin
            refs_ra = r_idx;
            prev_ra = prev_rd;
            next_ra = prev_rd;
        end
    end

    // Reference count writes.
    always_comb begin
        refs_we = 1'b0;
        refs_wa = r_idx;
        refs_wd = '0;
        if (i_cmd.init_wr) begin
            refs_we = (r_init_cnt != HEAD);
            refs_wa = IDX_W'(r_init_cnt);
        end else if (i_cmd.refs_inc) begin
            refs_we = 1'b1;
            refs_wd = refs_inc;
        end else if (i_cmd.refs_dec) begin
            refs_we = 1'b1;
            refs_wd = refs_dec;
        end else if (i_cmd.fill) begin
            refs_we = 1'b1;
            refs_wa = IDX_W'(prev_rd);
            refs_wd = REF_BITS'(1);
        end
    end

    // Ring pointer writes. A push to the front is split into push1 and push2
    // because each pointer array is written twice.
    always_comb begin
        next_we = 1'b0;
        next_wa = r_init_cnt;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = r_init_cnt;
        prev_wd = '0;
        if (i_cmd.init_wr) begin
            next_we = 1'b1;
            next_wd = (r_init_cnt == HEAD) ? '0 : PTR_W'(r_init_cnt + 1'b1);
            prev_we = 1'b1;
            prev_wd = (r_init_cnt == '0) ? HEAD : PTR_W'(r_init_cnt - 1'b1);
        end else if (i_cmd.unlink) begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
        end else if (i_cmd.push1) begin
            next_we = 1'b1;
            next_wa = idx_ptr;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = idx_ptr;
            prev_wd = HEAD;
        end else if (i_cmd.push2) begin
            next_we = 1'b1;
            next_wa = HEAD;
            next_wd = idx_ptr;
            prev_we = 1'b1;
            prev_wa = r_q;
            prev_wd = idx_ptr;
        end
    end

    rlec_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (SLOTS)
    ) u_refs (
        .i_clk     (i_clk),
        .i_wr_en   (refs_we),
        .i_wr_addr (refs_wa),
        .i_wr_data (refs_wd),
        .i_rd_addr (refs_ra),
        .o_rd_data (refs_rd)
    );

    rlec_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS + 1)
    ) u_next (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_addr (next_ra),
        .o_rd_data (next_rd)
    );

    rlec_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS + 1)
    ) u_prev (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_addr (prev_ra),
        .o_rd_data (prev_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
        end else if (i_cmd.init_wr) begin
            r_init_cnt <= PTR_W'(r_init_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_obj      <= key;
            r_slot     <= i_slot;
            r_idx      <= i_action ? slot_idx : cam_idx;
            r_hit      <= cam_hit;
            r_in_range <= slot_ok;
        end
        if (i_cmd.fill) begin
            r_victim <= IDX_W'(prev_rd);
        end
        if (i_cmd.push1) begin
            r_q <= next_rd;
        end
    end

    always_comb begin
        n_res_status = i_cmd.res_status;
        n_res_slot   = '0;
        n_res_count  = '0;
        n_res_fill   = 1'b0;
        case (i_cmd.res_status)
            ST_HIT: begin
                n_res_slot  = SLOT_FIELD_W'(r_idx);
                n_res_count = COUNT_FIELD_W'(refs_inc);
            end
            ST_MISS: begin
                n_res_slot  = SLOT_FIELD_W'(r_victim);
                n_res_count = COUNT_FIELD_W'(1);
                n_res_fill  = 1'b1;
            end
            ST_OVERFLOW: begin
                n_res_slot  = SLOT_FIELD_W'(r_idx);
                n_res_count = COUNT_FIELD_W'(refs_rd);
            end
            ST_HELD: begin
                n_res_slot  = r_slot;
                n_res_count = COUNT_FIELD_W'(refs_dec);
            end
            ST_NOW_IDLE: begin
                n_res_slot = r_slot;
            end
            ST_BAD_RELEASE: begin
                n_res_slot = r_slot;
            end
            default: begin
                n_res_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= n_res_status;
            r_res_slot   <= n_res_slot;
            r_res_count  <= n_res_count;
            r_res_fill   <= n_res_fill;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_count  <= r_res_count;
            r_out_fill   <= r_res_fill;
        end
    end

    assign o_sts.is_put     = r_action;
    assign o_sts.hit        = r_hit;
    assign o_sts.in_range   = r_in_range;
    assign o_sts.refs_zero  = (refs_rd == '0);
    assign o_sts.refs_one   = (refs_rd == REF_BITS'(1));
    assign o_sts.refs_max   = (refs_rd == REF_MAX);
    assign o_sts.ring_empty = (prev_rd == HEAD);
    assign o_sts.init_last  = (r_init_cnt == HEAD);

    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;
    assign o_ref_count  = r_out_count;
    assign o_needs_fill = r_out_fill;

    `RLEC_ASSERT_IMPLY(a_ring_one_writer, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.init_wr, i_cmd.unlink, i_cmd.push1, i_cmd.push2}))
    `RLEC_ASSERT_NEXT(a_push_completes, i_clk, i_rst_n, i_cmd.push1, i_cmd.push2)
    `RLEC_ASSERT_NEXT(a_fill_unlinks, i_clk, i_rst_n, i_cmd.fill, i_cmd.unlink)
    `RLEC_ASSERT_IMPLY(a_release_held, i_clk, i_rst_n, i_cmd.refs_dec,
        r_in_range && (refs_rd != '0))

endmodule

@@ rtl/rlec_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlec_ctrl
// Sequencer for lookup, count update, idle ring update and result hand-off.
// ----------------------------------------------------------------------------
`include "refcounted_lru_entry_cache_core_assert.svh"

module rlec_ctrl
    import rlec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_UNLINK,
        S_PUSH,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.res_status = ST_HIT;
        out_free       = !r_out_valid || i_out_ready;
        case (r_state)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.lookup = 1'b1;
                if (i_in_valid && r_in_ready) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.res_load = 1'b1;
                n_state      = S_EMIT;
                if (i_sts.is_put) begin
                    if (!i_sts.in_range || i_sts.refs_zero) begin
                        cmd.res_status = ST_BAD_RELEASE;
                    end else if (i_sts.refs_one) begin
                        cmd.refs_dec   = 1'b1;
                        cmd.push1      = 1'b1;
                        cmd.res_status = ST_NOW_IDLE;
                        n_state        = S_PUSH;
                    end else begin
                        cmd.refs_dec   = 1'b1;
                        cmd.res_status = ST_HELD;
                    end
                end else if (i_sts.hit) begin
                    if (i_sts.refs_max) begin
                        cmd.res_status = ST_OVERFLOW;
                    end else begin
                        // A hit on an idle entry also takes it off the ring.
                        cmd.refs_inc   = 1'b1;
                        cmd.unlink     = i_sts.refs_zero;
                        cmd.res_status = ST_HIT;
                    end
                end else if (i_sts.ring_empty) begin
                    cmd.res_status = ST_NO_IDLE;
                end else begin
                    cmd.res_load = 1'b0;
                    cmd.fill     = 1'b1;
                    n_state      = S_UNLINK;
                end
            end
            S_UNLINK: begin
                cmd.unlink     = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_MISS;
                n_state        = S_EMIT;
            end
            S_PUSH: begin
                cmd.push2 = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_in_ready  = (n_state == S_IDLE);
        n_out_valid = cmd.out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    `RLEC_ASSERT_IMPLY(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid),
        $past(cmd.out_load))

endmodule

@@ rtl/refcounted_lru_entry_cache_core.sv @@
// ----------------------------------------------------------------------------
// refcounted_lru_entry_cache_core
// Reference-counted object entry table with least-recently-released reuse.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one request word:
//   a get (action 0) looks up i_object_number, a put (action 1) releases
//   i_slot. Every request produces exactly one word on the output channel
//   (o_out_valid / i_out_ready) with status, slot, count and a fill flag.
//   A request goes from the evaluate state to the emit state; a miss that
//   retags an idle entry goes through an unlink state and a release that
//   drops a count to zero through a push state. A miss must read the
//   victim's ring neighbors before it can unlink it, and a push to the front
//   writes each idle ring pointer RAM twice. Requests are handled one at a
//   time: the next word is accepted once the result is in the output register.
//   After reset the block sweeps the count and ring RAMs, one entry per
//   cycle, from entry 0 through the ring head SLOTS, with o_in_ready low.
//   The result sits in an output register; while the receiver stalls, the
//   next request is still accepted and worked on, and its result waits in
//   a staging register until the output word is taken.
// ----------------------------------------------------------------------------
module refcounted_lru_entry_cache_core
    import rlec_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int OBJECT_BITS = DEF_OBJECT_BITS,
    parameter int REF_BITS    = DEF_REF_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic [OBJ_FIELD_W-1:0]   i_object_number,
    input  logic [SLOT_FIELD_W-1:0]  i_slot,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_FIELD_W-1:0]  o_slot_index,
    output logic [COUNT_FIELD_W-1:0] o_ref_count,
    output logic                     o_needs_fill
);

    t_cmd cmd;
    t_sts sts;

    rlec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rlec_datapath #(
        .SLOTS       (SLOTS),
        .OBJECT_BITS (OBJECT_BITS),
        .REF_BITS    (REF_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_object_number (i_object_number),
        .i_slot          (i_slot),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_ref_count     (o_ref_count),
        .o_needs_fill    (o_needs_fill)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for refcounted_lru_entry_cache_core
// Sends get and put request words through the valid/ready input channel,
// predicts each result word with a cycle-free model of the entry table and
// its idle ring, and compares every result field in order of arrival. The
// run goes through directed corner cases, a back-to-back full-table phase
// and a long mostly well-formed random phase, with random idling on both
// channels, a long receiver stall and full drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
    import rlec_pkg::*;

    localparam int NSLOT       = DEF_SLOTS;
    localparam int HEAD_NODE   = NSLOT;
    localparam int N_RANDOM    = 1200;
    localparam int POOL_SIZE   = 96;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam logic [OBJ_FIELD_W-1:0] OVF_OBJ = 24'h7E5A01;

    typedef struct packed {
        logic                    action;
        logic [OBJ_FIELD_W-1:0]  obj;
        logic [SLOT_FIELD_W-1:0] slot;
    } cache_req_t;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_FIELD_W-1:0] count;
        logic                     fill;
    } cache_reply_t;

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_ready;
    logic                     i_action        = ACT_GET;
    logic [OBJ_FIELD_W-1:0]   i_object_number = '0;
    logic [SLOT_FIELD_W-1:0]  i_slot          = '0;
    logic                     o_out_valid;
    logic                     i_out_ready     = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic [SLOT_FIELD_W-1:0]  o_slot_index;
    logic [COUNT_FIELD_W-1:0] o_ref_count;
    logic                     o_needs_fill;

    refcounted_lru_entry_cache_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_object_number (i_object_number),
        .i_slot          (i_slot),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_ref_count     (o_ref_count),
        .o_needs_fill    (o_needs_fill)
    );

    // Shadow of the entry table and its idle ring.
    logic [OBJ_FIELD_W-1:0]  m_tag   [NSLOT];
    logic                    m_valid [NSLOT];
    logic [DEF_REF_BITS-1:0] m_refs  [NSLOT];
    logic                    m_idle  [NSLOT];
    logic [6:0]              m_next  [NSLOT+1];
    logic [6:0]              m_prev  [NSLOT+1];

    cache_req_t   requests_queued [$];
    cache_reply_t replies_due     [$];

    int          words_accepted = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          status_tally [7];
    int          tx_gap  = 0;
    int          tx_calm = 0;
    int          rx_gap  = 0;
    int          rx_calm = 0;
    int          rx_hold = 0;
    logic        rx_hold_done = 1'b0;
    int          rx_hold_mark = 32'h7fff_ffff;
    logic        fast_phase   = 1'b0;
    int unsigned cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void ring_unlink(int n);
        int p;
        int q;
        p = m_prev[n];
        q = m_next[n];
        m_next[p] = 7'(q);
        m_prev[q] = 7'(p);
        m_next[n] = 7'(n);
        m_prev[n] = 7'(n);
    endfunction

    function automatic void ring_push_mru(int n);
        int q;
        q = m_next[HEAD_NODE];
        m_prev[n]         = 7'(HEAD_NODE);
        m_next[n]         = 7'(q);
        m_prev[q]         = 7'(n);
        m_next[HEAD_NODE] = 7'(n);
    endfunction

    // Applies one request word to the shadow table and returns its result word.
    function automatic cache_reply_t cache_apply(cache_req_t r);
        cache_reply_t rep;
        int found;
        int victim;
        int i;
        rep = '0;
        if (r.action == ACT_GET) begin
            found = -1;
            for (i = 0; i < NSLOT; i++) begin
                if (found < 0 && m_valid[i] && m_tag[i] == r.obj) found = i;
            end
            if (found >= 0) begin
                rep.slot = found[SLOT_FIELD_W-1:0];
                if (m_refs[found] == '1) begin
                    rep.status = ST_OVERFLOW;
                end else begin
                    if (m_idle[found]) begin
                        ring_unlink(found);
                        m_idle[found] = 1'b0;
                    end
                    m_refs[found] = m_refs[found] + 1'b1;
                    rep.status = ST_HIT;
                end
                rep.count = m_refs[found];
            end else begin
                victim = m_prev[HEAD_NODE];
                if (victim >= NSLOT) begin
                    rep.status = ST_NO_IDLE;
                end else begin
                    ring_unlink(victim);
                    m_idle[victim]  = 1'b0;
                    m_tag[victim]   = r.obj;
                    m_valid[victim] = 1'b1;
                    m_refs[victim]  = DEF_REF_BITS'(1);
                    rep.status = ST_MISS;
                    rep.slot   = victim[SLOT_FIELD_W-1:0];
                    rep.count  = COUNT_FIELD_W'(1);
                    rep.fill   = 1'b1;
                end
            end
        end else begin
            rep.slot = r.slot;
            if (m_refs[r.slot] == 0) begin
                rep.status = ST_BAD_RELEASE;
            end else begin
                m_refs[r.slot] = m_refs[r.slot] - 1'b1;
                if (m_refs[r.slot] == 0) begin
                    if (!m_idle[r.slot]) begin
                        ring_push_mru(r.slot);
                        m_idle[r.slot] = 1'b1;
                    end
                    rep.status = ST_NOW_IDLE;
                end else begin
                    rep.status = ST_HELD;
                    rep.count  = m_refs[r.slot];
                end
            end
        end
        return rep;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_get(logic [OBJ_FIELD_W-1:0] obj,
                                      logic [SLOT_FIELD_W-1:0] noise);
        requests_queued.push_back('{ACT_GET, obj, noise});
    endfunction

    function automatic void queue_put(logic [SLOT_FIELD_W-1:0] slot,
                                      logic [OBJ_FIELD_W-1:0] noise);
        requests_queued.push_back('{ACT_PUT, noise, slot});
    endfunction

    task automatic wait_drained();
        while (requests_queued.size() != 0 || i_in_valid || replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : req_driver
        cache_req_t nxt;
        logic       fire;
        int         g;
        fire = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
            tx_calm    <= 0;
        end else if (!(i_in_valid && !fire)) begin
            g = tx_gap;
            if (fire) begin
                replies_due.push_back(cache_apply('{i_action, i_object_number, i_slot}));
                words_accepted <= words_accepted + 1;
                if (fast_phase || tx_calm != 0) g = 0;
                else g = draw_gap();
                if (tx_calm != 0) tx_calm <= tx_calm - 1;
                else if ($urandom_range(0, 39) == 0) tx_calm <= $urandom_range(30, 80);
            end
            if (g != 0) begin
                tx_gap     <= g - 1;
                i_in_valid <= 1'b0;
            end else if (requests_queued.size() != 0) begin
                nxt = requests_queued.pop_front();
                i_action        <= nxt.action;
                i_object_number <= nxt.obj;
                i_slot          <= nxt.slot;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the output and staging registers fill so that
    // the block has to stall its input while the driver keeps offering.
    always @(posedge i_clk) begin : result_receiver
        int g;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!rx_hold_done && results_seen >= rx_hold_mark) begin
            rx_hold      <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
            i_out_ready  <= 1'b0;
        end else if (fast_phase) begin
            i_out_ready <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap      <= rx_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            g = 0;
            if (o_out_valid && i_out_ready) begin
                if (rx_calm == 0) g = draw_gap();
                if (rx_calm != 0) rx_calm <= rx_calm - 1;
                else if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(30, 80);
            end
            if (g != 0) begin
                rx_gap      <= g - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic flag_bad_reply(string why, cache_reply_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at result %0d: want st=%0d slot=%0d cnt=%0d fill=%0d, %s",
                     why, results_seen, want.status, want.slot, want.count, want.fill,
                     $sformatf("got st=%0d slot=%0d cnt=%0d fill=%0d",
                               o_status, o_slot_index, o_ref_count, o_needs_fill));
    endtask

    always @(posedge i_clk) begin : result_checker
        cache_reply_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (replies_due.size() == 0) begin
                flag_bad_reply("unexpected word", '0);
            end else begin
                want = replies_due.pop_front();
                status_tally[want.status] = status_tally[want.status] + 1;
                if (o_status !== want.status || o_slot_index !== want.slot ||
                    o_ref_count !== want.count || o_needs_fill !== want.fill)
                    flag_bad_reply("field", want);
            end
        end
    end

    always @(posedge i_clk) begin : run_timer
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL refcounted_lru_entry_cache_core");
            $finish;
        end
    end

    initial begin : stimulus
        logic [OBJ_FIELD_W-1:0] obj_pool [POOL_SIZE];
        int held_list [$];
        int made;
        int batch;
        int s;
        int k;
        int put_pct;
        for (s = 0; s < NSLOT; s++) begin
            m_tag[s]   = '0;
            m_valid[s] = 1'b0;
            m_refs[s]  = '0;
            m_idle[s]  = 1'b1;
        end
        for (s = 0; s <= NSLOT; s++) begin
            m_next[s] = 7'((s == NSLOT) ? 0 : s + 1);
            m_prev[s] = 7'((s == 0) ? NSLOT : s - 1);
        end
        for (s = 0; s < 7; s++) status_tally[s] = 0;
        for (s = 0; s < POOL_SIZE; s++) obj_pool[s] = OBJ_FIELD_W'($urandom);
        obj_pool[0] = '0;
        obj_pool[1] = '1;
        obj_pool[2] = OVF_OBJ;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corner cases: releases on empty slots, first victims from the top,
        // hits on idle entries that kept their tag, reuse of the oldest idle.
        queue_put(6'd0, 24'hFFFFFF);
        queue_put(6'd63, 24'h000000);
        queue_get(24'h000000, 6'd63);
        queue_get(24'hFFFFFF, 6'd0);
        queue_get(24'h000000, 6'd21);
        queue_put(6'd63, 24'h123456);
        queue_put(6'd63, 24'hABCDEF);
        queue_put(6'd63, 24'h000000);
        queue_get(24'h000000, 6'd42);
        queue_put(6'd62, 24'hFFFFFF);
        queue_get(24'hA5A5A5, 6'd63);
        queue_get(24'h5A5A5A, 6'd0);
        queue_put(6'd63, 24'h5A5A5A);
        queue_get(24'hFFFFFF, 6'd31);
        queue_get(24'h123456, 6'd32);
        queue_put(6'd61, 24'h0);
        queue_put(6'd60, 24'h0);
        queue_put(6'd59, 24'h0);
        queue_get(24'h5A5A5A, 6'd0);
        queue_get(24'h000001, 6'd63);
        wait_drained();

        // Fill every slot back to back, then keep asking so the idle ring
        // runs dry.
        fast_phase = 1'b1;
        for (k = 0; k < 68; k++) queue_get(OBJ_FIELD_W'(24'h3C0000 + k), 6'(k));
        queue_get(24'h3C0000, 6'd0);
        queue_get(24'h000001, 6'd1);
        wait_drained();
        fast_phase = 1'b0;

        for (s = 0; s < NSLOT; s++)
            for (k = 0; k < m_refs[s]; k++) queue_put(6'(s), OBJ_FIELD_W'($urandom));
        wait_drained();

        rx_hold_mark = results_seen + 150;
        made  = 0;
        batch = 0;
        while (made < N_RANDOM) begin
            while (requests_queued.size() != 0) @(negedge i_clk);
            batch++;
            if (batch % 40 == 0) wait_drained();
            held_list.delete();
            for (s = 0; s < NSLOT; s++) if (m_refs[s] != 0) held_list.push_back(s);
            put_pct = (held_list.size() > 56) ? 60 : 42;
            repeat (8) begin
                if ($urandom_range(0, 99) < put_pct) begin
                    if (held_list.size() != 0 && $urandom_range(0, 99) < 85)
                        queue_put(6'(held_list[$urandom_range(0, held_list.size() - 1)]),
                                  OBJ_FIELD_W'($urandom));
                    else
                        queue_put(6'($urandom), OBJ_FIELD_W'($urandom));
                end else begin
                    if ($urandom_range(0, 99) < 85)
                        queue_get(obj_pool[$urandom_range(0, POOL_SIZE - 1)], 6'($urandom));
                    else
                        queue_get(OBJ_FIELD_W'($urandom), 6'($urandom));
                end
                made++;
            end
        end
        wait_drained();
        repeat (16) @(negedge i_clk);

        $display("Run: %0d request words, %0d result words, %0d mismatches",
                 words_accepted, results_seen, mismatches);
        $display("Results: hit %0d, miss %0d, no idle %0d, overflow %0d, %s",
                 status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_NO_IDLE],
                 status_tally[ST_OVERFLOW],
                 $sformatf("held %0d, now idle %0d, bad release %0d",
                           status_tally[ST_HELD], status_tally[ST_NOW_IDLE],
                           status_tally[ST_BAD_RELEASE]));
        if (mismatches == 0) begin
            $display("PASS refcounted_lru_entry_cache_core");
        end else begin
            $display("FAIL refcounted_lru_entry_cache_core");
        end
        $finish;
    end

endmodule
